### hdl/btc_pkg.sv
// Shared types, constants and the control store for the balanced ternary converter.
// Used by btc_sequencer, btc_datapath and balanced_ternary_converter_core.
package btc_pkg;

  localparam int INT_DIGITS  = 21;
  localparam int FRAC_DIGITS = 19;

  localparam int NUM_W = 31;
  // digit positions span the whole numerator: 3^20 > 2^31, plus one carry position
  localparam int DIG_N = INT_DIGITS;
  localparam int POS_W = $clog2(DIG_N);
  // exponent reaches FRAC_DIGITS + 1 when the power search overshoots
  localparam int EXP_W = $clog2(FRAC_DIGITS + 2);
  localparam int POW_W = NUM_W + 1;

  // floor(x / 3) = (x * RECIP3) >> RECIP_SH for any 32-bit x
  localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
  localparam int          RECIP_SH = 33;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_POW   = 4'd1;
  localparam step_t S_CHECK = 4'd2;
  localparam step_t S_DIV   = 4'd3;
  localparam step_t S_DIGIT = 4'd4;
  localparam step_t S_SETUP = 4'd5;
  localparam step_t S_EMIT  = 4'd6;
  localparam step_t S_DONE  = 4'd7;
  localparam step_t S_ERR   = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_POW,
    OP_DIV,
    OP_DIGIT,
    OP_SETUP,
    OP_EMIT,
    OP_ERR
  } op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_POW_LT,
    CND_BAD,
    CND_MORE_POS,
    CND_MORE_EMIT
  } cond_e;

  typedef struct packed {
    op_e   op;
    logic  wait_in;
    logic  wait_out;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic pow_lt;
    logic bad;
    logic more_pos;
    logic more_emit;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw = '{op: OP_NOP, wait_in: 1'b0, wait_out: 1'b0, cond: CND_ALWAYS, target: S_IDLE};
    unique case (step)
      S_IDLE:  cw = '{op: OP_LOAD,  wait_in: 1'b1, wait_out: 1'b0,
                      cond: CND_ALWAYS,    target: S_POW};
      S_POW:   cw = '{op: OP_POW,   wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_POW_LT,    target: S_POW};
      S_CHECK: cw = '{op: OP_NOP,   wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_BAD,       target: S_ERR};
      S_DIV:   cw = '{op: OP_DIV,   wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_NEVER,     target: S_IDLE};
      S_DIGIT: cw = '{op: OP_DIGIT, wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_MORE_POS,  target: S_DIV};
      S_SETUP: cw = '{op: OP_SETUP, wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_NEVER,     target: S_IDLE};
      S_EMIT:  cw = '{op: OP_EMIT,  wait_in: 1'b0, wait_out: 1'b1,
                      cond: CND_MORE_EMIT, target: S_EMIT};
      S_DONE:  cw = '{op: OP_NOP,   wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_ALWAYS,    target: S_IDLE};
      S_ERR:   cw = '{op: OP_ERR,   wait_in: 1'b0, wait_out: 1'b1,
                      cond: CND_ALWAYS,    target: S_IDLE};
      default: cw = '{op: OP_NOP,   wait_in: 1'b0, wait_out: 1'b0,
                      cond: CND_ALWAYS,    target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

### hdl/balanced_ternary_converter_core.sv
// Balanced ternary converter top level: sequencer plus datapath.
// Depends on btc_pkg, btc_sequencer and btc_datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | numerator_i[30:0], denominator_i[30:0]
//  out     | out_valid_o / out_stall_i | digit_o[1:0] (signed), in_fraction_o,
//          |                        | bad_denominator_o, last_o
//
// The 21-position base-3 sweep takes two steps per digit through the shared
// reciprocal multiplier, then sends one digit per cycle out of the digit store
// while the output is not stalled; a bad denominator skips the sweep.
// A new item is taken only once the last result of the previous one is registered.
// Reset clears the step counter and the output valid flag; a stall holds the output
// register and the emit step.
module balanced_ternary_converter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [btc_pkg::NUM_W-1:0] numerator_i,
  input  logic [btc_pkg::NUM_W-1:0] denominator_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [1:0]         digit_o,
  output logic                      in_fraction_o,
  output logic                      bad_denominator_o,
  output logic                      last_o
);
  import btc_pkg::*;

  ctrl_t   cw;
  status_t status;
  logic    go;

  btc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cw_o       (cw),
    .go_o       (go)
  );

  btc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cw_i              (cw),
    .go_i              (go),
    .numerator_i       (numerator_i),
    .denominator_i     (denominator_i),
    .out_stall_i       (out_stall_i),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .digit_o           (digit_o),
    .in_fraction_o     (in_fraction_o),
    .bad_denominator_o (bad_denominator_o),
    .last_o            (last_o)
  );

  // only the load step takes an item
  assign in_stall_o = !cw.wait_in;

endmodule

### hdl/btc_sequencer.sv
// Step counter and control store lookup for the balanced ternary converter.
// Depends on btc_pkg for the control word, status flags and the program.
module btc_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  btc_pkg::status_t status_i,
  output btc_pkg::ctrl_t   cw_o,
  output logic             go_o
);
  import btc_pkg::*;

  step_t pc_q, pc_d;
  ctrl_t cw;
  logic  take;

  assign cw = ucode(pc_q);

  // hold the step while its handshake is not ready
  assign go_o = !((cw.wait_in && !in_valid_i) || (cw.wait_out && !status_i.out_free));

  always_comb begin
    unique case (cw.cond)
      CND_NEVER:     take = 1'b0;
      CND_ALWAYS:    take = 1'b1;
      CND_POW_LT:    take = status_i.pow_lt;
      CND_BAD:       take = status_i.bad;
      CND_MORE_POS:  take = status_i.more_pos;
      CND_MORE_EMIT: take = status_i.more_emit;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (!go_o) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign cw_o = cw;

endmodule

### hdl/btc_datapath.sv
// Working registers, divide-by-three unit, digit store and output register.
// Depends on btc_pkg; driven by control words from btc_sequencer.
module btc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  btc_pkg::ctrl_t              cw_i,
  input  logic                        go_i,
  input  logic [btc_pkg::NUM_W-1:0]   numerator_i,
  input  logic [btc_pkg::NUM_W-1:0]   denominator_i,
  input  logic                        out_stall_i,
  output btc_pkg::status_t            status_o,
  output logic                        out_valid_o,
  output logic signed [1:0]           digit_o,
  output logic                        in_fraction_o,
  output logic                        bad_denominator_o,
  output logic                        last_o
);
  import btc_pkg::*;

  logic [NUM_W-1:0] num_q, den_q, quo_q;
  logic [POW_W-1:0] pow_q;
  logic [EXP_W-1:0] exp_q;
  logic [POS_W-1:0] pos_q, lo_q, hi_q, idx_q, stop_q;
  logic             carry_q, nz_q;
  logic [1:0]       dig_q [DIG_N];

  logic             out_valid_q;
  logic signed [1:0] digit_q;
  logic             frac_q, bad_q, last_q;

  logic [63:0]      prod;
  logic [NUM_W-1:0] rem_full;
  logic [2:0]       sum;
  logic             carry_n;
  logic [1:0]       bal;
  logic [POS_W-1:0] exp_pos, start_pos, stop_pos;
  logic             exec, out_free;

  assign exec     = go_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign exp_pos  = POS_W'(exp_q);

  assign prod     = 64'(num_q) * 64'(RECIP3);
  assign rem_full = num_q - (quo_q + {quo_q[NUM_W-2:0], 1'b0});

  // plain digit + 1 + carry, fold back into -1/0/+1
  always_comb begin
    sum     = 3'(rem_full[1:0]) + 3'd1 + 3'(carry_q);
    carry_n = (sum >= 3'd3);
    unique case (carry_n ? (sum - 3'd3) : sum)
      3'd0:    bal = 2'b11;
      3'd1:    bal = 2'b00;
      default: bal = 2'b01;
    endcase
  end

  assign start_pos = (nz_q && (hi_q >= exp_pos)) ? hi_q : exp_pos;
  assign stop_pos  = (nz_q && (lo_q <  exp_pos)) ? lo_q : exp_pos;

  assign status_o = '{
    out_free:  out_free,
    pow_lt:    (pow_q < {1'b0, den_q}),
    bad:       (pow_q != {1'b0, den_q}),
    more_pos:  (pos_q != POS_W'(DIG_N - 1)),
    more_emit: (idx_q != stop_q)
  };

  always_ff @(posedge clk_i) begin
    if (exec) begin
      unique case (cw_i.op)
        OP_LOAD: begin
          num_q   <= numerator_i;
          den_q   <= denominator_i;
          pow_q   <= POW_W'(1);
          exp_q   <= '0;
          pos_q   <= '0;
          carry_q <= 1'b0;
          nz_q    <= 1'b0;
          lo_q    <= '0;
          hi_q    <= '0;
        end
        OP_POW: begin
          if (pow_q < {1'b0, den_q}) begin
            pow_q <= pow_q + {pow_q[POW_W-2:0], 1'b0};
            exp_q <= exp_q + EXP_W'(1);
          end
        end
        OP_DIV: begin
          quo_q <= prod[RECIP_SH +: NUM_W];
        end
        OP_DIGIT: begin
          dig_q[pos_q] <= bal;
          if (bal != 2'b00) begin
            if (!nz_q) begin
              lo_q <= pos_q;
            end
            nz_q <= 1'b1;
            hi_q <= pos_q;
          end
          carry_q <= carry_n;
          num_q   <= quo_q;
          pos_q   <= pos_q + POS_W'(1);
        end
        OP_SETUP: begin
          idx_q  <= start_pos;
          stop_q <= stop_pos;
        end
        OP_EMIT: begin
          idx_q <= idx_q - POS_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (exec && cw_i.op == OP_EMIT) begin
      digit_q <= dig_q[idx_q];
      frac_q  <= (idx_q < exp_pos);
      bad_q   <= 1'b0;
      last_q  <= (idx_q == stop_q);
    end else if (exec && cw_i.op == OP_ERR) begin
      digit_q <= 2'sb00;
      frac_q  <= 1'b0;
      bad_q   <= 1'b1;
      last_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && (cw_i.op == OP_EMIT || cw_i.op == OP_ERR)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign digit_o           = digit_q;
  assign in_fraction_o     = frac_q;
  assign bad_denominator_o = bad_q;
  assign last_o            = last_q;

endmodule
